### rtl/cslx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cslx_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int TEXT_LIMIT_DEF    = 63;
	localparam int QUEUE_DEPTH       = 4;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_NUMBER,
		MODE_OP,
		MODE_HALT
	} scan_mode_t;

	typedef enum logic [1:0] {
		OP_EQ,
		OP_BANG,
		OP_LT,
		OP_GT
	} pend_op_t;

	localparam logic [4:0] KIND_EOF    = 5'd0;
	localparam logic [4:0] KIND_IDENT  = 5'd1;
	localparam logic [4:0] KIND_NUMBER = 5'd2;
	localparam logic [4:0] KIND_INT    = 5'd3;
	localparam logic [4:0] KIND_RETURN = 5'd4;
	localparam logic [4:0] KIND_IF     = 5'd5;
	localparam logic [4:0] KIND_ELSE   = 5'd6;
	localparam logic [4:0] KIND_WHILE  = 5'd7;
	localparam logic [4:0] KIND_EQEQ   = 5'd8;
	localparam logic [4:0] KIND_PLUS   = 5'd12;
	localparam logic [4:0] KIND_MINUS  = 5'd13;
	localparam logic [4:0] KIND_STAR   = 5'd14;
	localparam logic [4:0] KIND_SLASH  = 5'd15;
	localparam logic [4:0] KIND_ASSIGN = 5'd16;
	localparam logic [4:0] KIND_LT     = 5'd17;
	localparam logic [4:0] KIND_GT     = 5'd18;
	localparam logic [4:0] KIND_LPAREN = 5'd19;
	localparam logic [4:0] KIND_RPAREN = 5'd20;
	localparam logic [4:0] KIND_LBRACE = 5'd21;
	localparam logic [4:0] KIND_RBRACE = 5'd22;
	localparam logic [4:0] KIND_COMMA  = 5'd23;
	localparam logic [4:0] KIND_SEMI   = 5'd24;
	localparam logic [4:0] KIND_ERROR  = 5'd25;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [5:0]  length;
		logic [7:0]  bad;
		logic        last;
	} token_t;

	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} push_t;

endpackage

`default_nettype wire

### rtl/cslx_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cslx_front #(
	parameter int POSITION_BITS = cslx_pkg::POSITION_BITS_DEF,
	parameter int TEXT_LIMIT    = cslx_pkg::TEXT_LIMIT_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    code_byte,
	input  wire logic          end_of_source,
	output cslx_pkg::push_t    push
);
	import cslx_pkg::*;

	localparam logic [5:0] LEN_CAP = 6'((TEXT_LIMIT < 63) ? TEXT_LIMIT : 63);

	localparam logic [47:0] KW_INT    = 48'h0000_0074_6E69;
	localparam logic [47:0] KW_RETURN = 48'h6E72_7574_6572;
	localparam logic [47:0] KW_IF     = 48'h0000_0000_6669;
	localparam logic [47:0] KW_ELSE   = 48'h0000_6573_6C65;
	localparam logic [47:0] KW_WHILE  = 48'h0065_6C69_6877;

	scan_mode_t               mode_q, mode_n;
	pend_op_t                 pend_q, pend_n;
	logic [POSITION_BITS-1:0] origin_q, origin_n;
	logic [POSITION_BITS-1:0] pos_q, pos_n;
	logic [5:0]               run_q, run_n;
	logic [47:0]              prefix_q, prefix_n;

	logic       is_space, is_alpha, is_digit, is_alnum, is_eq;
	logic       op_hit, punct_hit;
	pend_op_t   op_code;
	logic [4:0] punct_kind;
	logic       fl_valid, fl_halt, start_en;
	token_t     fl_tok, a_tok, b_tok;
	logic       a_v, b_v;
	logic [4:0] word_kind;
	logic [31:0] origin_ext, pos_ext;

	assign is_space = (code_byte == 8'h20) || (code_byte >= 8'h09 && code_byte <= 8'h0D);
	assign is_alpha = (code_byte >= 8'h61 && code_byte <= 8'h7A)
		|| (code_byte >= 8'h41 && code_byte <= 8'h5A) || (code_byte == 8'h5F);
	assign is_digit = (code_byte >= 8'h30 && code_byte <= 8'h39);
	assign is_alnum = is_alpha || is_digit;
	assign is_eq    = (code_byte == 8'h3D);

	always_comb begin
		op_hit  = 1'b1;
		op_code = OP_EQ;
		unique case (code_byte)
			8'h3D: op_code = OP_EQ;
			8'h21: op_code = OP_BANG;
			8'h3C: op_code = OP_LT;
			8'h3E: op_code = OP_GT;
			default: op_hit = 1'b0;
		endcase
	end

	always_comb begin
		punct_hit  = 1'b1;
		punct_kind = KIND_ERROR;
		unique case (code_byte)
			8'h2B: punct_kind = KIND_PLUS;
			8'h2D: punct_kind = KIND_MINUS;
			8'h2A: punct_kind = KIND_STAR;
			8'h2F: punct_kind = KIND_SLASH;
			8'h28: punct_kind = KIND_LPAREN;
			8'h29: punct_kind = KIND_RPAREN;
			8'h7B: punct_kind = KIND_LBRACE;
			8'h7D: punct_kind = KIND_RBRACE;
			8'h2C: punct_kind = KIND_COMMA;
			8'h3B: punct_kind = KIND_SEMI;
			default: punct_hit = 1'b0;
		endcase
	end

	assign origin_ext = 32'(origin_q);
	assign pos_ext    = 32'(pos_q);

	// a saturated word has run_q >= 7 and never matches a keyword
	always_comb begin
		word_kind = KIND_IDENT;
		if (run_q == 6'd3 && prefix_q == KW_INT)
			word_kind = KIND_INT;
		else if (run_q == 6'd6 && prefix_q == KW_RETURN)
			word_kind = KIND_RETURN;
		else if (run_q == 6'd2 && prefix_q == KW_IF)
			word_kind = KIND_IF;
		else if (run_q == 6'd4 && prefix_q == KW_ELSE)
			word_kind = KIND_ELSE;
		else if (run_q == 6'd5 && prefix_q == KW_WHILE)
			word_kind = KIND_WHILE;
	end

	// token left pending by the current state
	always_comb begin
		fl_valid = 1'b0;
		fl_halt  = 1'b0;
		fl_tok   = '0;
		fl_tok.start = origin_ext[15:0];
		unique case (mode_q)
			MODE_WORD: begin
				fl_valid      = 1'b1;
				fl_tok.kind   = word_kind;
				fl_tok.length = run_q;
			end
			MODE_NUMBER: begin
				fl_valid      = 1'b1;
				fl_tok.kind   = KIND_NUMBER;
				fl_tok.length = run_q;
			end
			MODE_OP: begin
				fl_valid      = 1'b1;
				fl_tok.length = 6'd1;
				unique case (pend_q)
					OP_EQ:   fl_tok.kind = KIND_ASSIGN;
					OP_LT:   fl_tok.kind = KIND_LT;
					OP_GT:   fl_tok.kind = KIND_GT;
					OP_BANG: begin
						fl_tok.kind = KIND_ERROR;
						fl_tok.bad  = 8'h21;
						fl_halt     = 1'b1;
					end
				endcase
			end
			MODE_IDLE, MODE_HALT: ;
			default: ;
		endcase
	end

	// the byte may open a new token once any pending one is resolved
	assign start_en = !end_of_source && !is_space && (
		(mode_q == MODE_IDLE) ||
		(mode_q == MODE_WORD && !is_alnum) ||
		(mode_q == MODE_NUMBER && !is_digit) ||
		(mode_q == MODE_OP && !is_eq && !fl_halt));

	// next state
	always_comb begin
		mode_n   = mode_q;
		pend_n   = pend_q;
		origin_n = origin_q;
		run_n    = run_q;
		prefix_n = prefix_q;
		pos_n    = pos_q + 1'b1;
		if (end_of_source) begin
			mode_n   = MODE_IDLE;
			pend_n   = OP_EQ;
			origin_n = '0;
			run_n    = '0;
			prefix_n = '0;
			pos_n    = '0;
		end else begin
			unique case (mode_q)
				MODE_WORD, MODE_NUMBER: begin
					if ((mode_q == MODE_WORD && is_alnum) || is_digit) begin
						for (int i = 0; i < 6; i++) begin
							if (run_q == 6'(i))
								prefix_n[8*i +: 8] = code_byte;
						end
						if (run_q < LEN_CAP)
							run_n = run_q + 6'd1;
					end else begin
						mode_n = MODE_IDLE;
					end
				end
				MODE_OP: begin
					pend_n = OP_EQ;
					mode_n = (!is_eq && fl_halt) ? MODE_HALT : MODE_IDLE;
				end
				MODE_IDLE, MODE_HALT: ;
				default: ;
			endcase
			if (start_en) begin
				priority if (is_alnum) begin
					mode_n   = is_digit ? MODE_NUMBER : MODE_WORD;
					origin_n = pos_q;
					run_n    = 6'd1;
					prefix_n = {40'd0, code_byte};
				end else if (op_hit) begin
					mode_n   = MODE_OP;
					pend_n   = op_code;
					origin_n = pos_q;
				end else if (punct_hit) begin
					mode_n = MODE_IDLE;
				end else begin
					mode_n = MODE_HALT;
				end
			end
		end
	end

	// tokens caused by this item: a is the resolved pending one, b the new one
	always_comb begin
		a_v   = 1'b0;
		b_v   = 1'b0;
		a_tok = fl_tok;
		b_tok = '0;
		b_tok.start = pos_ext[15:0];
		if (end_of_source) begin
			a_v         = fl_valid;
			b_v         = (mode_q != MODE_HALT) && !fl_halt;
			b_tok.kind  = KIND_EOF;
		end else begin
			unique case (mode_q)
				MODE_WORD:   a_v = !is_alnum;
				MODE_NUMBER: a_v = !is_digit;
				MODE_OP: begin
					a_v = 1'b1;
					if (is_eq) begin
						a_tok.kind   = KIND_EQEQ + {3'd0, pend_q};
						a_tok.length = 6'd2;
						a_tok.bad    = 8'd0;
					end
				end
				MODE_IDLE, MODE_HALT: ;
				default: ;
			endcase
			if (start_en && !is_alnum && !op_hit) begin
				b_v          = 1'b1;
				b_tok.length = 6'd1;
				if (punct_hit) begin
					b_tok.kind = punct_kind;
				end else begin
					b_tok.kind = KIND_ERROR;
					b_tok.bad  = code_byte;
				end
			end
		end
		b_tok.last = 1'b1;
		a_tok.last = !b_v;
	end

	always_comb begin
		push = '0;
		if (accept) begin
			push.count  = {1'b0, a_v} + {1'b0, b_v};
			push.first  = a_v ? a_tok : b_tok;
			push.second = b_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pend_q   <= OP_EQ;
			origin_q <= '0;
			pos_q    <= '0;
			run_q    <= '0;
			prefix_q <= '0;
		end else if (accept) begin
			mode_q   <= mode_n;
			pend_q   <= pend_n;
			origin_q <= origin_n;
			pos_q    <= pos_n;
			run_q    <= run_n;
			prefix_q <= prefix_n;
		end
	end

endmodule

`default_nettype wire

### rtl/cslx_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cslx_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cslx_pkg::push_t  push,
	input  wire logic             pop,
	output logic                  room,
	output logic                  nonempty,
	output cslx_pkg::token_t      head
);
	import cslx_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	token_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   count_q;
	logic [PTR_W-1:0]   wr_next;

	assign wr_next  = wr_q + 1'b1;
	assign nonempty = (count_q != '0);
	// two free entries cover the worst case of one item
	assign room     = (count_q <= CNT_W'(QUEUE_DEPTH - 2));
	assign head     = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			slots_q[wr_q] <= push.first;
		if (push.count == 2'd2)
			slots_q[wr_next] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push.count);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

### rtl/cslx_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cslx_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             nonempty,
	input  wire cslx_pkg::token_t head,
	output logic                  pop,
	input  wire logic             out_stall,
	output logic                  out_valid,
	output cslx_pkg::token_t      tok
);
	import cslx_pkg::*;

	logic   valid_q;
	token_t tok_q;
	logic   load;

	// refill the output register when empty or when its token transfers
	assign load      = !valid_q || !out_stall;
	assign pop       = load && nonempty;
	assign out_valid = valid_q;
	assign tok       = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= nonempty;
	end

	always_ff @(posedge clk) begin
		if (pop)
			tok_q <= head;
	end

endmodule

`default_nettype wire

### rtl/c_subset_lexer_unit.sv
// Channel | Signals                                               | Direction
// input   | in_valid, in_stall, code_byte, end_of_source          | into block
// output  | out_valid, out_stall, token_kind, token_start,        | out of block
//         | token_length, bad_byte, last_of_run                   |
//
// One source byte is taken per cycle while the token queue has two free entries.
// Tokens leave one per cycle from the output register while out_stall is low, so items
// that yield two tokens are paced by the output side; the first token passes through
// the queue and then the output register before it is on the output.
// Front scanner and output side stall independently through a four-entry queue.
// Asynchronous active-low reset clears scanner state, queue pointers and out_valid.
`timescale 1ns / 1ps
`default_nettype none

module c_subset_lexer_unit #(
	parameter int POSITION_BITS = cslx_pkg::POSITION_BITS_DEF,
	parameter int TEXT_LIMIT    = cslx_pkg::TEXT_LIMIT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  code_byte,
	input  wire logic        end_of_source,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       token_kind,
	output logic [15:0]      token_start,
	output logic [5:0]       token_length,
	output logic [7:0]       bad_byte,
	output logic             last_of_run
);
	import cslx_pkg::*;

	push_t  push;
	token_t head, tok;
	logic   room, nonempty, pop, accept;

	assign in_stall = !room;
	assign accept   = in_valid && room;

	cslx_front #(
		.POSITION_BITS(POSITION_BITS),
		.TEXT_LIMIT(TEXT_LIMIT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.code_byte(code_byte),
		.end_of_source(end_of_source),
		.push(push)
	);

	cslx_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(pop),
		.room(room),
		.nonempty(nonempty),
		.head(head)
	);

	cslx_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.nonempty(nonempty),
		.head(head),
		.pop(pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.tok(tok)
	);

	assign token_kind   = tok.kind;
	assign token_start  = tok.start;
	assign token_length = tok.length;
	assign bad_byte     = tok.bad;
	assign last_of_run  = tok.last;

endmodule

`default_nettype wire

### rtl/cslx_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cslx_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [7:0]  code_byte,
	input wire logic        end_of_source,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [4:0]  token_kind,
	input wire logic [15:0] token_start,
	input wire logic [5:0]  token_length,
	input wire logic [7:0]  bad_byte,
	input wire logic        last_of_run
);
	import cslx_pkg::*;

	// hold a stalled token
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind)
			&& $stable(token_start) && $stable(token_length)
			&& $stable(bad_byte) && $stable(last_of_run))
		else $error("stalled token changed");

	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_EOF |->
			token_length == 6'd0 && last_of_run && bad_byte == 8'd0)
		else $error("malformed eof token");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_ERROR |-> token_length == 6'd1 && last_of_run)
		else $error("malformed error token");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != KIND_ERROR |-> bad_byte == 8'd0)
		else $error("bad_byte set on a regular token");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_kind <= KIND_ERROR && (token_kind < KIND_EQEQ
			|| token_kind > KIND_GT || token_length != 6'd0))
		else $error("token kind out of range");

endmodule

bind c_subset_lexer_unit cslx_checker u_cslx_checker (.*);

`default_nettype wire

### test/c_subset_lexer_unit_test.sv
`timescale 1ns / 1ps

module c_subset_lexer_unit_test;
	import cslx_pkg::*;

	localparam int ITEM_TARGET    = 750;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  code_byte;
	logic        end_of_source;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  token_kind;
	logic [15:0] token_start;
	logic [5:0]  token_length;
	logic [7:0]  bad_byte;
	logic        last_of_run;

	class token_scoreboard;
		localparam logic [5:0] LENGTH_CAP = 6'd63;

		token_t      expected_tokens[$];
		int          errors;
		int          checked;
		scan_mode_t  mode;
		pend_op_t    pend_op;
		logic [15:0] origin;
		logic [5:0]  run_len;
		logic [47:0] prefix;
		logic [15:0] position;

		function new();
			errors = 0;
			checked = 0;
			rearm();
		endfunction

		function void rearm();
			mode = MODE_IDLE;
			pend_op = OP_EQ;
			origin = '0;
			run_len = '0;
			prefix = '0;
			position = '0;
		endfunction

		function bit is_space(logic [7:0] b);
			return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
		endfunction

		function bit is_alpha(logic [7:0] b);
			return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
		endfunction

		function bit is_digit(logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function void push(logic [4:0] kind, logic [15:0] start, logic [5:0] length,
				logic [7:0] bad);
			token_t t;
			t = {kind, start, length, bad, 1'b0};
			expected_tokens.push_back(t);
		endfunction

		// Only the first six bytes are kept; length stops at the cap.
		function void grow(logic [7:0] b);
			if (run_len < 6) begin
				prefix |= 48'(b) << (8 * run_len);
			end
			if (run_len < LENGTH_CAP) begin
				run_len++;
			end
		endfunction

		function logic [4:0] word_kind();
			case (run_len)
			6'd2: if (prefix == 48'h6669) return KIND_IF;
			6'd3: if (prefix == 48'h746E69) return KIND_INT;
			6'd4: if (prefix == 48'h65736C65) return KIND_ELSE;
			6'd5: if (prefix == 48'h656C696877) return KIND_WHILE;
			6'd6: if (prefix == 48'h6E7275746572) return KIND_RETURN;
			default: ;
			endcase
			return KIND_IDENT;
		endfunction

		function void flush();
			case (mode)
			MODE_WORD: begin
				push(word_kind(), origin, run_len, 8'h00);
				mode = MODE_IDLE;
			end
			MODE_NUMBER: begin
				push(KIND_NUMBER, origin, run_len, 8'h00);
				mode = MODE_IDLE;
			end
			MODE_OP: begin
				mode = MODE_IDLE;
				case (pend_op)
				OP_BANG: begin
					push(KIND_ERROR, origin, 6'd1, "!");
					mode = MODE_HALT;
				end
				OP_LT: push(KIND_LT, origin, 6'd1, 8'h00);
				OP_GT: push(KIND_GT, origin, 6'd1, 8'h00);
				default: push(KIND_ASSIGN, origin, 6'd1, 8'h00);
				endcase
				pend_op = OP_EQ;
			end
			default: ;
			endcase
		endfunction

		function void start_token(logic [7:0] b, logic [15:0] here);
			if (is_alpha(b) || is_digit(b)) begin
				mode = is_digit(b) ? MODE_NUMBER : MODE_WORD;
				origin = here;
				run_len = '0;
				prefix = '0;
				grow(b);
			end else begin
				case (b)
				"=": begin mode = MODE_OP; pend_op = OP_EQ; origin = here; end
				"!": begin mode = MODE_OP; pend_op = OP_BANG; origin = here; end
				"<": begin mode = MODE_OP; pend_op = OP_LT; origin = here; end
				">": begin mode = MODE_OP; pend_op = OP_GT; origin = here; end
				"+": push(KIND_PLUS, here, 6'd1, 8'h00);
				"-": push(KIND_MINUS, here, 6'd1, 8'h00);
				"*": push(KIND_STAR, here, 6'd1, 8'h00);
				"/": push(KIND_SLASH, here, 6'd1, 8'h00);
				"(": push(KIND_LPAREN, here, 6'd1, 8'h00);
				")": push(KIND_RPAREN, here, 6'd1, 8'h00);
				"{": push(KIND_LBRACE, here, 6'd1, 8'h00);
				"}": push(KIND_RBRACE, here, 6'd1, 8'h00);
				",": push(KIND_COMMA, here, 6'd1, 8'h00);
				";": push(KIND_SEMI, here, 6'd1, 8'h00);
				default: begin
					push(KIND_ERROR, here, 6'd1, b);
					mode = MODE_HALT;
				end
				endcase
			end
		endfunction

		function void note_item(logic [7:0] code, logic eos);
			int          queued;
			logic [15:0] here;
			bit          taken;
			queued = expected_tokens.size();
			if (eos) begin
				flush();
				if (mode != MODE_HALT) begin
					push(KIND_EOF, position, 6'd0, 8'h00);
				end
				rearm();
			end else begin
				here = position;
				position = position + 16'd1;
				// after an error every byte is dropped
				taken = (mode == MODE_HALT);
				case (mode)
				MODE_WORD: begin
					if (is_alpha(code) || is_digit(code)) begin
						grow(code);
						taken = 1'b1;
					end else begin
						flush();
					end
				end
				MODE_NUMBER: begin
					if (is_digit(code)) begin
						grow(code);
						taken = 1'b1;
					end else begin
						flush();
					end
				end
				MODE_OP: begin
					if (code == "=") begin
						push(KIND_EQEQ + 5'(pend_op), origin, 6'd2, 8'h00);
						mode = MODE_IDLE;
						pend_op = OP_EQ;
						taken = 1'b1;
					end else begin
						flush();
						taken = (mode == MODE_HALT);
					end
				end
				default: ;
				endcase
				if (!taken && mode == MODE_IDLE && !is_space(code)) begin
					start_token(code, here);
				end
			end
			if (expected_tokens.size() > queued) begin
				expected_tokens[expected_tokens.size() - 1].last = 1'b1;
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) begin
				$display("ERROR: %s", msg);
			end
		endtask

		task compare_field(string field, int got_value, int want_value);
			if (got_value != want_value) begin
				report($sformatf("token %0d %s: got %0d, expected %0d", checked, field,
					got_value, want_value));
			end
		endtask

		task check_token(token_t got);
			token_t want;
			checked++;
			if (expected_tokens.size() == 0) begin
				report($sformatf("token %0d (kind %0d at %0d) with nothing expected",
					checked, got.kind, got.start));
			end else begin
				want = expected_tokens.pop_front();
				compare_field("kind", got.kind, want.kind);
				compare_field("start", got.start, want.start);
				compare_field("length", got.length, want.length);
				compare_field("bad byte", got.bad, want.bad);
				compare_field("last", got.last, want.last);
			end
		endtask

		task check_leftovers();
			if (expected_tokens.size() != 0) begin
				report($sformatf("%0d expected tokens never arrived", expected_tokens.size()));
			end
		endtask
	endclass

	token_scoreboard lexer_sb;
	logic [7:0]      source_text[$];
	int              items_sent;
	int              idle_cycles;
	bit              steady_in;
	bit              steady_out;

	string keyword_text[5] = '{"int", "return", "if", "else", "while"};
	string operator_text[17] = '{"==", "!=", "<=", ">=", "+", "-", "*", "/", "=", "<", ">",
		"(", ")", "{", "}", ",", ";"};
	logic [7:0] blank_bytes[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	c_subset_lexer_unit i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_item(input logic [7:0] code, input logic eos);
		int gap;
		gap = steady_in ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_byte <= code;
		end_of_source <= eos;
		do @(posedge clk); while (in_stall);
		if (eos || lexer_sb.mode != MODE_HALT) begin
			items_sent++;
		end
		lexer_sb.note_item(code, eos);
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_item(s[i], 1'b0);
		end
	endtask

	function automatic logic [7:0] word_byte(bit lead);
		case ($urandom_range(0, lead ? 3 : 5))
		0, 1: return 8'("a" + $urandom_range(0, 25));
		2: return 8'("A" + $urandom_range(0, 25));
		3: return "_";
		default: return 8'("0" + $urandom_range(0, 9));
		endcase
	endfunction

	function automatic void append_string(string s);
		for (int i = 0; i < s.len(); i++) begin
			source_text.push_back(s[i]);
		end
	endfunction

	function automatic void append_word(int n);
		source_text.push_back(word_byte(1'b1));
		for (int i = 1; i < n; i++) begin
			source_text.push_back(word_byte(1'b0));
		end
	endfunction

	function automatic void append_number(int n);
		for (int i = 0; i < n; i++) begin
			source_text.push_back(8'("0" + $urandom_range(0, 9)));
		end
	endfunction

	// Near misses matter as much as the keywords themselves.
	function automatic void append_keyword();
		string kw;
		kw = keyword_text[$urandom_range(0, 4)];
		case ($urandom_range(0, 6))
		0: kw = kw.substr(0, kw.len() - 2);
		1: kw = {kw, "s"};
		2: kw = {kw, "1"};
		3: kw = kw.toupper();
		default: ;
		endcase
		append_string(kw);
	endfunction

	function automatic void append_blank();
		repeat ($urandom_range(1, 2)) source_text.push_back(blank_bytes[$urandom_range(0, 5)]);
	endfunction

	function automatic void append_noise();
		if ($urandom_range(0, 1) == 0) begin
			source_text.push_back("!");
		end else begin
			source_text.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	function automatic void build_text(int text_index);
		int lexemes;
		int noise_at;
		source_text.delete();
		lexemes = $urandom_range(0, 24);
		noise_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, lexemes) : -1;
		if (text_index % 6 == 3) begin
			append_word($urandom_range(60, 80));
			append_blank();
		end
		if (text_index % 6 == 4) begin
			append_number($urandom_range(60, 80));
		end
		for (int i = 0; i < lexemes; i++) begin
			if (i == noise_at) begin
				append_noise();
			end
			case ($urandom_range(0, 9))
			0, 1, 2: append_word($urandom_range(1, 8));
			3, 4: append_keyword();
			5, 6: append_number($urandom_range(1, 6));
			default: append_string(operator_text[$urandom_range(0, 16)]);
			endcase
			// leave some lexemes touching so adjacency rules get exercised
			if ($urandom_range(0, 9) < 6) begin
				append_blank();
			end
		end
		if (noise_at == lexemes) begin
			append_noise();
		end
	endfunction

	initial begin : drain
		int hold;
		hold = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				lexer_sb.check_token({token_kind, token_start, token_length, bad_byte,
					last_of_run});
				hold = steady_out ? 0 : $urandom_range(0, 3);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TIMEOUT: no transfer for %0d cycles", idle_cycles);
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int text_index;
		lexer_sb = new();
		items_sent = 0;
		idle_cycles = 0;
		steady_in = 1'b0;
		steady_out = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		code_byte <= 8'h00;
		end_of_source <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone bang at the end: error only, no end-of-file token
		send_string("if 9a<=_Z!");
		send_item(8'hFF, 1'b1);
		send_item(8'hFF, 1'b1);
		send_item("=", 1'b0);
		send_item(8'h00, 1'b0);
		send_string("ab");
		send_item(8'h00, 1'b1);
		send_string("!x");
		send_item(8'h5A, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'h80, 1'b1);

		text_index = 0;
		while (items_sent < ITEM_TARGET) begin
			build_text(text_index);
			steady_in = (text_index % 4 == 1);
			steady_out = (text_index % 5 == 2);
			foreach (source_text[i]) begin
				send_item(source_text[i], 1'b0);
			end
			send_item(8'($urandom_range(0, 255)), 1'b1);
			text_index++;
		end
		in_valid <= 1'b0;

		while (lexer_sb.expected_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		lexer_sb.check_leftovers();
		if (lexer_sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
